// File: src/qpdec_pkg.sv
// Shared types, character constants and helpers for the quoted-printable decoder.
package qpdec_pkg;

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int unsigned NIBBLE_SHIFT    = 4;
  localparam int unsigned HEX_LETTER_BASE = 10;

  // Most results one beat can produce.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Result queue, power of two so the pointers wrap on their own.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,  // no escape pending
    PH_EQ   = 2'd1,  // '=' seen
    PH_HELD = 2'd2   // '=' and one byte seen
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       empty;
    logic       last;
  } result_t;

  // Results of one input beat, in order; entries at and above count are unused.
  typedef struct packed {
    logic [RES_CNT_W-1:0]         count;
    result_t [MAX_RESULTS-1:0]    res;
  } decode_t;

  // Bit 4 set: not a hex digit. Bits 3:0: digit value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h41 + 8'(HEX_LETTER_BASE))};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h61 + 8'(HEX_LETTER_BASE))};
    end
    return v;
  endfunction

endpackage

// File: src/qpdec_if.sv
// Valid/ready channel interfaces for encoded input and decoded output.
interface qpdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qpdec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_empty;
  logic       out_last;

  modport source (output valid, output out_byte, output out_empty, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_empty, input out_last,
                  output ready);
endinterface

// File: src/quoted_printable_decoder_top.sv
// Top level of the streaming quoted-printable decoder.
//
// Usage:
//   in_ch carries one encoded byte per beat (in_byte) plus in_last on the
//   final byte of a message. out_ch carries decoded bytes (out_byte); out_last
//   marks the final result of a message, and out_empty marks a result that
//   carries only the end mark (out_byte then reads zero).
//   "=XY" (hex, either case) decodes to one byte; "=" CR LF is a soft line
//   break and yields nothing; any other "=" sequence passes its "=" through and
//   rescans the bytes after it; one cut off by in_last passes through unchanged.
// Ordering: each result is registered in the queue before it is offered.
// Throughput: one input beat per cycle while the receiver takes one result
//   per cycle. A beat yields zero to three results; the queue drains one a
//   cycle while the receiver is ready, so a broken escape or an end flush can
//   stall input. in_ready is high while the four-entry queue holds one result
//   or fewer.
// Reset: rst_n (synchronous, active low) empties the queue and clears the
//   escape state. When the receiver stalls, results wait in the queue and
//   in_ready drops once it holds more than one result.
module quoted_printable_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  qpdec_in_if.sink           in_ch,
  qpdec_out_if.source        out_ch
);

  qpdec_pkg::phase_t   phase_r;
  qpdec_pkg::phase_t   phase_nxt;
  logic [7:0]          held_r;
  logic [7:0]          held_nxt;
  qpdec_pkg::decode_t  dec;
  qpdec_pkg::result_t  head;
  logic                room;
  logic                in_fire;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid && room;

  // Escape decode: pure logic between the escape state and the queue.
  qpdec_decode u_decode (
    .phase     (phase_r),
    .held      (held_r),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .phase_nxt (phase_nxt),
    .held_nxt  (held_nxt),
    .dec       (dec)
  );

  // Escape state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qpdec_pkg::PH_IDLE;
      held_r  <= 8'h00;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  // Results queue; it is the register stage between the two channels.
  qpdec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_dec  (dec),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (head)
  );

  assign out_ch.out_byte  = head.data;
  assign out_ch.out_empty = head.empty;
  assign out_ch.out_last  = head.last;

endmodule

// File: src/qpdec_decode.sv
// Combinational escape decode of one input beat against the current escape state.
module qpdec_decode (
  input  qpdec_pkg::phase_t  phase,
  input  logic [7:0]         held,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output qpdec_pkg::phase_t  phase_nxt,
  output logic [7:0]         held_nxt,
  output qpdec_pkg::decode_t dec
);

  logic [4:0] hi_v;
  logic [4:0] lo_v;

  assign hi_v = qpdec_pkg::hex_value(held);
  assign lo_v = qpdec_pkg::hex_value(in_byte);

  always_comb begin
    logic [7:0]                        e_v [qpdec_pkg::MAX_RESULTS];
    logic [qpdec_pkg::RES_CNT_W-1:0]   cnt_v;
    qpdec_pkg::phase_t                 ph_v;
    logic [7:0]                        hd_v;
    logic                              empty_v;

    for (int i = 0; i < qpdec_pkg::MAX_RESULTS; i++) e_v[i] = 8'h00;
    cnt_v   = '0;
    ph_v    = qpdec_pkg::PH_IDLE;
    hd_v    = held;
    empty_v = 1'b0;

    unique case (phase)
      qpdec_pkg::PH_HELD: begin
        hd_v = 8'h00;
        if (held == qpdec_pkg::CH_CR && in_byte == qpdec_pkg::CH_LF) begin
          ph_v = qpdec_pkg::PH_IDLE;  // soft line break
        end else if (!hi_v[4] && !lo_v[4]) begin
          e_v[0] = {hi_v[3:0], lo_v[3:0]};
          cnt_v  = 2'd1;
        end else begin
          // broken escape: pass '=' and rescan the two bytes from idle
          e_v[0] = qpdec_pkg::CH_EQ;
          if (held == qpdec_pkg::CH_EQ) begin
            ph_v  = qpdec_pkg::PH_HELD;
            hd_v  = in_byte;
            cnt_v = 2'd1;
          end else begin
            e_v[1] = held;
            if (in_byte == qpdec_pkg::CH_EQ) begin
              ph_v  = qpdec_pkg::PH_EQ;
              cnt_v = 2'd2;
            end else begin
              e_v[2] = in_byte;
              cnt_v  = 2'd3;
            end
          end
        end
      end
      qpdec_pkg::PH_EQ: begin
        ph_v = qpdec_pkg::PH_HELD;
        hd_v = in_byte;
      end
      default: begin
        // idle, and the unused code
        if (in_byte == qpdec_pkg::CH_EQ) begin
          ph_v = qpdec_pkg::PH_EQ;
        end else begin
          e_v[0] = in_byte;
          cnt_v  = 2'd1;
        end
      end
    endcase

    // End of message: flush a pending escape as plain text.
    if (in_last) begin
      if (ph_v == qpdec_pkg::PH_EQ) begin
        if (cnt_v != 2'(qpdec_pkg::MAX_RESULTS)) begin
          e_v[cnt_v[1:0]] = qpdec_pkg::CH_EQ;
          cnt_v = cnt_v + 1'b1;
        end
      end else if (ph_v == qpdec_pkg::PH_HELD) begin
        if (cnt_v != 2'(qpdec_pkg::MAX_RESULTS)) begin
          e_v[cnt_v[1:0]] = qpdec_pkg::CH_EQ;
          cnt_v = cnt_v + 1'b1;
        end
        if (cnt_v != 2'(qpdec_pkg::MAX_RESULTS)) begin
          e_v[cnt_v[1:0]] = hd_v;
          cnt_v = cnt_v + 1'b1;
        end
      end
      ph_v = qpdec_pkg::PH_IDLE;
      hd_v = 8'h00;
      if (cnt_v == '0) begin
        empty_v = 1'b1;
        e_v[0]  = 8'h00;
        cnt_v   = 2'd1;
      end
    end

    phase_nxt = ph_v;
    held_nxt  = hd_v;
    dec.count = cnt_v;
    for (int i = 0; i < qpdec_pkg::MAX_RESULTS; i++) begin
      dec.res[i].data  = e_v[i];
      dec.res[i].empty = empty_v;
      dec.res[i].last  = in_last && (i == int'(cnt_v) - 1);
    end
  end

endmodule

// File: src/qpdec_queue.sv
// Small result queue: takes up to three results a cycle while it has room, hands out one while out_ready is high.
module qpdec_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qpdec_pkg::decode_t push_dec,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output qpdec_pkg::result_t out_res
);

  qpdec_pkg::result_t                 mem_r [qpdec_pkg::QUEUE_DEPTH];
  logic [qpdec_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [qpdec_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [qpdec_pkg::QCNT_W-1:0]       cnt_r;
  logic [qpdec_pkg::QCNT_W-1:0]       push_n;
  logic                               pop;

  // room for a full beat's worth of results
  assign room      = cnt_r <= qpdec_pkg::QCNT_W'(qpdec_pkg::QUEUE_DEPTH - qpdec_pkg::MAX_RESULTS);
  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign push_n    = push ? qpdec_pkg::QCNT_W'(push_dec.count) : '0;

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < qpdec_pkg::MAX_RESULTS; i++) begin
        if (i < int'(push_dec.count)) begin
          mem_r[wr_ptr_r + qpdec_pkg::QPTR_W'(i)] <= push_dec.res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + qpdec_pkg::QPTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + qpdec_pkg::QPTR_W'(pop);
      cnt_r    <= cnt_r + push_n - qpdec_pkg::QCNT_W'(pop);
    end
  end

endmodule

// File: src/qpdec_checker.sv
// Port-level checks for the quoted-printable decoder, bound to the top level.
module qpdec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_empty,
  input logic       out_last
);

  // An end-mark-only result always closes its message.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last)
    else $error("empty result without out_last");

  // An end-mark-only result reads zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_byte == 8'h00)
    else $error("empty result with nonzero byte");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_empty)
      && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind quoted_printable_decoder_top qpdec_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_empty (out_ch.out_empty),
  .out_last  (out_ch.out_last)
);

// File: tb/sv/quoted_printable_decoder_top_tb.sv
// Self-checking testbench for the quoted-printable decoder: directed and random messages.
module quoted_printable_decoder_top_tb;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RAND_ITEMS = 220;
  localparam int unsigned NUM_PHASES = 4;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } enc_beat_t;

  logic clk;
  logic rst_n;

  qpdec_in_if  in_ch();
  qpdec_out_if out_ch();

  quoted_printable_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Encoded beats waiting to be driven, and decoded results waiting to arrive.
  enc_beat_t           enc_q[$];
  qpdec_pkg::result_t  decoded_q[$];

  // Decoder state as we track it; reset values match the block after rst_n.
  qpdec_pkg::phase_t qp_phase = qpdec_pkg::PH_IDLE;
  logic [7:0]        qp_held  = 8'h00;
  logic [7:0]        beat_bytes[$];  // bytes produced by the beat being decoded

  int unsigned        send_idle_pct = 0;
  int unsigned        stall_pct     = 0;
  int unsigned        mismatches    = 0;
  int unsigned        cycles        = 0;
  int unsigned        phase_items   = 0;
  enc_beat_t          drv_next;
  qpdec_pkg::result_t want;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Hex digit value, or -1 for anything that is not a hex digit.
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + qpdec_pkg::HEX_LETTER_BASE;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + qpdec_pkg::HEX_LETTER_BASE;
    return -1;
  endfunction

  // Byte handling outside a complete escape: starts an escape, holds the byte
  // after '=', or copies the byte through.
  function automatic void take_plain(input logic [7:0] b);
    if (qp_phase == qpdec_pkg::PH_EQ) begin
      qp_held  = b;
      qp_phase = qpdec_pkg::PH_HELD;
    end else if (b == qpdec_pkg::CH_EQ) begin
      qp_phase = qpdec_pkg::PH_EQ;
    end else begin
      qp_phase = qpdec_pkg::PH_IDLE;
      beat_bytes.push_back(b);
    end
  endfunction

  // Works out the results of one accepted beat and queues them.
  function automatic void decode_beat(input logic [7:0] b, input logic last);
    logic [7:0]         first;
    int                 hi;
    int                 lo;
    qpdec_pkg::result_t r;
    int                 n;
    beat_bytes.delete();
    if (qp_phase == qpdec_pkg::PH_HELD) begin
      first    = qp_held;
      hi       = hex_digit(first);
      lo       = hex_digit(b);
      qp_phase = qpdec_pkg::PH_IDLE;
      qp_held  = 8'h00;
      // '=' CR LF is a soft line break: nothing comes out
      if (!(first == qpdec_pkg::CH_CR && b == qpdec_pkg::CH_LF)) begin
        if (hi >= 0 && lo >= 0) begin
          beat_bytes.push_back(8'(hi * 16 + lo));
        end else begin
          // broken escape: pass '=' through, then rescan both bytes from idle
          beat_bytes.push_back(qpdec_pkg::CH_EQ);
          take_plain(first);
          take_plain(b);
        end
      end
    end else begin
      take_plain(b);
    end
    if (last) begin
      // escape cut short by the end of the message goes out unchanged
      if (qp_phase == qpdec_pkg::PH_EQ) begin
        beat_bytes.push_back(qpdec_pkg::CH_EQ);
      end else if (qp_phase == qpdec_pkg::PH_HELD) begin
        beat_bytes.push_back(qpdec_pkg::CH_EQ);
        beat_bytes.push_back(qp_held);
      end
      qp_phase = qpdec_pkg::PH_IDLE;
      qp_held  = 8'h00;
    end
    if (last && beat_bytes.size() == 0) begin
      // end mark alone
      r.data  = 8'h00;
      r.empty = 1'b1;
      r.last  = 1'b1;
      decoded_q.push_back(r);
    end else begin
      n = (beat_bytes.size() > qpdec_pkg::MAX_RESULTS) ? qpdec_pkg::MAX_RESULTS
                                                       : beat_bytes.size();
      for (int k = 0; k < n; k++) begin
        r.data  = beat_bytes[k];
        r.empty = 1'b0;
        r.last  = last && (k == n - 1);
        decoded_q.push_back(r);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat from enc_q per handshake, with random gaps.
  // The accepted beat is handed to the predictor at the edge it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'h00;
      in_ch.in_last <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_beat(in_ch.in_byte, in_ch.in_last);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (enc_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_next = enc_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= drv_next.b;
          in_ch.in_last <= drv_next.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, each result beat checked against the oldest
  // expectation. out_byte is checked on end-mark beats too (it must read zero).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte=%h out_empty=%b out_last=%b",
                 out_ch.out_byte, out_ch.out_empty, out_ch.out_last);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.out_empty !== want.empty) begin
            $error("out_empty: expected %b, got %b", want.empty, out_ch.out_empty);
            mismatches++;
          end
          if (out_ch.out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_ch.out_last);
            mismatches++;
          end
        end
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_beat(input logic [7:0] b, input logic last);
    enc_beat_t e;
    e.b    = b;
    e.last = last;
    enc_q.push_back(e);
  endtask

  // Whole message from text; in_last rides on the final character.
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_beat(s[i], i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] hex_char(input int unsigned v, input bit lower);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((lower ? 8'h61 : 8'h41) + v - 10);
  endfunction

  // Random message, mostly well-formed escapes and soft breaks among plain
  // text, with some raw bytes and broken escapes mixed in. Now and then the
  // tail is chopped so an escape gets cut by the end mark.
  task automatic push_random_message();
    logic [7:0] msg[$];
    int unsigned pick;
    logic [7:0] b;
    repeat ($urandom_range(8, 1)) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        b = 8'($urandom_range(126, 32));
        msg.push_back((b == qpdec_pkg::CH_EQ) ? 8'h20 : b);
      end else if (pick < 45) begin
        msg.push_back(8'($urandom_range(255)));
      end else if (pick < 75) begin
        msg.push_back(qpdec_pkg::CH_EQ);
        msg.push_back(hex_char($urandom_range(15), $urandom_range(1)));
        msg.push_back(hex_char($urandom_range(15), $urandom_range(1)));
      end else if (pick < 85) begin
        msg.push_back(qpdec_pkg::CH_EQ);
        msg.push_back(qpdec_pkg::CH_CR);
        msg.push_back(qpdec_pkg::CH_LF);
      end else begin
        msg.push_back(qpdec_pkg::CH_EQ);
        msg.push_back(8'($urandom_range(255)));
        if ($urandom_range(1)) msg.push_back(8'($urandom_range(255)));
      end
    end
    if (msg.size() > 2 && $urandom_range(9) == 0) void'(msg.pop_back());
    foreach (msg[i]) push_beat(msg[i], i == msg.size() - 1);
    phase_items += msg.size();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed messages.
    // Byte extremes, then escapes with digit boundaries in both cases.
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_text("=09=aF");
    // Soft break, then a broken escape that yields three bytes on the end beat.
    push_text("=\015\012x=G1");
    // Broken escape whose second '=' starts a good one.
    push_text("==41");
    // Soft break as the whole message: end mark with no byte.
    push_text("=\015\012");
    // Escapes cut short by the end mark.
    push_text("=");
    push_text("=B");
    // CR not followed by LF is not a soft break.
    push_text("=\015A");

    // Hold off until everything so far has come back out; polled between
    // edges so the driver and monitor have settled.
    while (enc_q.size() != 0 || in_ch.valid || decoded_q.size() != 0) @(negedge clk);

    // Random messages across the idle/stall phases.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      phase_items = 0;
      while (phase_items < RAND_ITEMS / NUM_PHASES) push_random_message();
      while (enc_q.size() != 0) @(posedge clk);
    end

    // Everything sent; wait for the last results, then a short tail to catch
    // anything extra.
    while (enc_q.size() != 0 || in_ch.valid || decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
